/* hdl/xor_key_frequency_breaker_unit_macros.svh */
// Assertion macros shared by the breaker RTL.
// No dependencies; included by xor_key_frequency_breaker_unit.sv, which carries the assertions.
`ifndef XOR_KEY_FREQUENCY_BREAKER_UNIT_MACROS_SVH
`define XOR_KEY_FREQUENCY_BREAKER_UNIT_MACROS_SVH

// Same-cycle implication, reset-qualified
`define XKFB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("xkfb: same-cycle check failed");

// Next-cycle implication, reset-qualified
`define XKFB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("xkfb: next-cycle check failed");

`endif

/* hdl/xkfb_pkg.sv */
// Shared constants, state encoding and status type for the XOR key breaker.
// No dependencies.
package xkfb_pkg;

    localparam int BLOCK_DEPTH = 32768;
    localparam int ADDR_W      = $clog2(BLOCK_DEPTH);
    localparam int CNT_W       = $clog2(BLOCK_DEPTH + 1);
    localparam int MAX_KEY_LEN = 29;
    localparam int KLEN_W      = 5;
    localparam int SCORE_W     = CNT_W + 1;
    localparam logic [7:0] SPACE_MASK = 8'h20;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;
    localparam logic KIND_DONE = 1'b0;
    localparam logic KIND_BYTE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COL_INIT,
        ST_RD_C,
        ST_RD_H,
        ST_UPD,
        ST_COL_END,
        ST_TRIAL_END,
        ST_A_DONE,
        ST_DIV,
        ST_R_OUT
    } xkfb_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } xkfb_div_stat_t;

endpackage

/* hdl/xkfb_mod_unit.sv */
// Bit-serial remainder unit: index mod key length, one quotient bit a cycle.
// Depends on xkfb_pkg.
module xkfb_mod_unit
    import xkfb_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [ADDR_W-1:0]   dividend,
    input  logic [KLEN_W-1:0]   divisor,
    output logic [KLEN_W-1:0]   remainder,
    output xkfb_div_stat_t      stat
);

    logic [ADDR_W-1:0]           num_reg;
    logic [KLEN_W:0]             rem_reg;
    logic [KLEN_W-1:0]           den_reg;
    logic [$clog2(ADDR_W+1)-1:0] cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [KLEN_W+1:0]           trial;
    logic [KLEN_W:0]             rem_next;

    // Shift in one dividend bit, subtract when it fits
    always_comb begin
        trial = {rem_reg, num_reg[ADDR_W-1]};
        if (trial >= {2'b00, den_reg}) begin
            trial = trial - {2'b00, den_reg};
        end
        rem_next = trial[KLEN_W:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == ($clog2(ADDR_W+1))'(ADDR_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then step
    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[ADDR_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign remainder = rem_reg[KLEN_W-1:0];
    assign stat      = '{busy: busy_reg, done: done_reg};

endmodule

/* hdl/xor_key_frequency_breaker_unit.sv */
// Repeating-key XOR breaker: loads ciphertext, finds key by column frequency, decodes on read.
// Depends on xkfb_pkg, xkfb_mod_unit and the assertion macro header.
//
// A load transaction (tuser = 0) gives no result unless tlast is set.
// A load with tlast starts the key search. For every trial length from T = min(29, n) down
// to 1, every column is swept through the block memory and the histogram memory; each
// stored byte goes through a block read, a histogram read and an update. A last pass at the
// chosen length L picks the key bytes, and the analysis result is then registered. A read
// transaction (tuser = 1) runs through the serial index-mod-length unit (15 steps and a
// done strobe), then the result is registered and the unit returns to idle before the
// next transaction; reads outside the loaded range take the same time. Input is held off
// while a result waits only when a second result is ready to be registered.
`include "xor_key_frequency_breaker_unit_macros.svh"

module xor_key_frequency_breaker_unit
    import xkfb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] cipher_byte, [22:8] index, [23] zero
    input  logic        s_tlast,   // last
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [4:0] key_length, [12:5] plain_byte, [15:13] zero
    output logic        m_tuser    // kind
);

    xkfb_state_t state_reg, state_next;

    // Block memory and histogram memory
    logic [7:0]  cipher_mem [BLOCK_DEPTH];
    logic [7:0]  cipher_q;
    logic [ADDR_W-1:0] cipher_raddr;
    logic [CNT_W-1:0]  hist_mem [256];
    logic [CNT_W-1:0]  hist_q;
    logic [255:0]      hvalid_reg;
    logic [7:0]        key_mem [MAX_KEY_LEN];

    logic [CNT_W-1:0]  n_reg;
    logic              done_blk_reg;
    logic [KLEN_W-1:0] chosen_reg;
    logic [KLEN_W-1:0] trial_reg;
    logic [KLEN_W-1:0] col_reg;
    logic [CNT_W-1:0]  pos_reg;
    logic [7:0]        byte_reg;
    logic [7:0]        pick_reg;
    logic signed [SCORE_W-1:0] score_reg;
    logic signed [SCORE_W-1:0] sum_reg;
    logic signed [SCORE_W-1:0] best_reg;
    logic              any_reg;
    logic              key_pass_reg;
    logic [ADDR_W-1:0] index_reg;
    logic              in_range_reg;
    logic [KLEN_W-1:0] kidx_reg;

    logic              m_valid_reg;
    logic [15:0]       m_data_reg;
    logic              m_user_reg;

    logic              in_acc;
    logic              slot_free;
    logic [7:0]        in_byte;
    logic [ADDR_W-1:0] in_index;
    logic [CNT_W-1:0]  n_base;
    logic [CNT_W-1:0]  n_new;
    logic              col_last;
    logic [CNT_W-1:0]  pos_first;
    logic [CNT_W-1:0]  pos_step;
    logic [CNT_W-1:0]  new_cnt;
    logic              div_start;
    logic [KLEN_W-1:0] div_rem;
    xkfb_div_stat_t    div_stat;

    assign in_byte   = s_tdata[7:0];
    assign in_index  = s_tdata[22:8];
    assign in_acc    = s_tvalid && s_tready;
    assign slot_free = !m_valid_reg || m_tready;
    assign n_base    = done_blk_reg ? '0 : n_reg;
    assign n_new     = (n_base < CNT_W'(BLOCK_DEPTH)) ? n_base + 1'b1 : n_base;
    assign col_last  = (col_reg == trial_reg - 1'b1);
    assign pos_first = {{(CNT_W-KLEN_W){1'b0}}, col_reg};
    assign pos_step  = pos_reg + {{(CNT_W-KLEN_W){1'b0}}, trial_reg};
    assign new_cnt   = hvalid_reg[byte_reg] ? hist_q + 1'b1 : CNT_W'(1);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_tuser == OP_READ) begin
                        state_next = ST_DIV;
                    end else if (s_tlast) begin
                        state_next = ST_COL_INIT;
                    end
                end
            end
            ST_COL_INIT:  state_next = (pos_first < n_reg) ? ST_RD_C : ST_COL_END;
            ST_RD_C:      state_next = ST_RD_H;
            ST_RD_H:      state_next = ST_UPD;
            ST_UPD:       state_next = (pos_step < n_reg) ? ST_RD_C : ST_COL_END;
            ST_COL_END: begin
                if (!col_last) begin
                    state_next = ST_COL_INIT;
                end else if (key_pass_reg) begin
                    state_next = ST_A_DONE;
                end else begin
                    state_next = ST_TRIAL_END;
                end
            end
            ST_TRIAL_END: state_next = ST_COL_INIT;
            ST_A_DONE:    state_next = slot_free ? ST_IDLE : ST_A_DONE;
            ST_DIV:       state_next = div_stat.done ? ST_R_OUT : ST_DIV;
            ST_R_OUT:     state_next = slot_free ? ST_IDLE : ST_R_OUT;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Handshake and control outputs
    always_comb begin
        s_tready     = 1'b0;
        div_start    = 1'b0;
        cipher_raddr = index_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                div_start = in_acc && (s_tuser == OP_READ);
            end
            ST_RD_C:  cipher_raddr = pos_reg[ADDR_W-1:0];
            default:  cipher_raddr = index_reg;
        endcase
    end

    xkfb_mod_unit u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (in_index),
        .divisor   (chosen_reg),
        .remainder (div_rem),
        .stat      (div_stat)
    );

    // Block memory: write on load, registered read
    always_ff @(posedge aclk) begin
        if (in_acc && s_tuser == OP_LOAD && n_base < CNT_W'(BLOCK_DEPTH)) begin
            cipher_mem[n_base[ADDR_W-1:0]] <= in_byte;
        end
        cipher_q <= cipher_mem[cipher_raddr];
    end

    // Histogram memory: read at the fetched byte, write back the new count
    always_ff @(posedge aclk) begin
        if (state_reg == ST_UPD) begin
            hist_mem[byte_reg] <= new_cnt;
        end
        hist_q <= hist_mem[cipher_q];
    end

    // Key store
    always_ff @(posedge aclk) begin
        if (state_reg == ST_COL_END && key_pass_reg) begin
            key_mem[col_reg] <= pick_reg ^ SPACE_MASK;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            n_reg        <= '0;
            done_blk_reg <= 1'b0;
            chosen_reg   <= KLEN_W'(1);
            best_reg     <= '0;
            hvalid_reg   <= '0;
            m_valid_reg  <= 1'b0;
            any_reg      <= 1'b0;
            key_pass_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // Raise the result flag when a result is registered, drop it once taken
            if ((state_reg == ST_A_DONE || state_reg == ST_R_OUT) && slot_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_acc && s_tuser == OP_LOAD) begin
                        n_reg        <= n_new;
                        done_blk_reg <= 1'b0;
                        any_reg      <= 1'b0;
                        key_pass_reg <= 1'b0;
                    end
                end
                ST_COL_INIT: hvalid_reg <= '0;
                ST_UPD:      hvalid_reg[byte_reg] <= 1'b1;
                ST_TRIAL_END: begin
                    if (!any_reg || sum_reg >= best_reg) begin
                        best_reg   <= sum_reg;
                        chosen_reg <= trial_reg;
                        any_reg    <= 1'b1;
                    end
                    if (trial_reg == KLEN_W'(1)) begin
                        key_pass_reg <= 1'b1;
                    end
                end
                ST_A_DONE: begin
                    if (slot_free) begin
                        done_blk_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    index_reg    <= in_index;
                    in_range_reg <= ({1'b0, in_index} < n_reg);
                    col_reg      <= '0;
                    sum_reg      <= '0;
                    trial_reg    <= (n_new < CNT_W'(MAX_KEY_LEN)) ?
                                    n_new[KLEN_W-1:0] : KLEN_W'(MAX_KEY_LEN);
                end
            end
            ST_COL_INIT: begin
                pos_reg   <= pos_first;
                score_reg <= -SCORE_W'(1);
                pick_reg  <= '0;
            end
            ST_RD_H: byte_reg <= cipher_q;
            ST_UPD: begin
                pos_reg <= pos_step;
                if (hvalid_reg[byte_reg]) begin
                    if (score_reg < $signed({1'b0, new_cnt})) begin
                        score_reg <= $signed({1'b0, new_cnt});
                        pick_reg  <= byte_reg;
                    end
                end else if (score_reg == -SCORE_W'(1)) begin
                    pick_reg <= byte_reg;
                end
            end
            ST_COL_END: begin
                sum_reg <= sum_reg + score_reg;
                col_reg <= col_reg + 1'b1;
            end
            ST_TRIAL_END: begin
                col_reg <= '0;
                sum_reg <= '0;
                if (trial_reg == KLEN_W'(1)) begin
                    trial_reg <= (!any_reg || sum_reg >= best_reg) ? trial_reg : chosen_reg;
                end else begin
                    trial_reg <= trial_reg - 1'b1;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    kidx_reg <= div_rem;
                end
            end
            ST_A_DONE: begin
                if (slot_free) begin
                    m_user_reg <= KIND_DONE;
                    m_data_reg <= {3'b000, 8'h00, chosen_reg};
                end
            end
            ST_R_OUT: begin
                if (slot_free) begin
                    m_user_reg <= KIND_BYTE;
                    m_data_reg <= {3'b000,
                                   in_range_reg ? (cipher_q ^ key_mem[kidx_reg]) : 8'h00,
                                   chosen_reg};
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    `XKFB_ASSERT_IMP(a_len_range, aclk, aresetn, 1'b1,
        (chosen_reg != '0) && (chosen_reg <= KLEN_W'(MAX_KEY_LEN)))
    `XKFB_ASSERT_IMP(a_fill_cap, aclk, aresetn, 1'b1, n_reg <= CNT_W'(BLOCK_DEPTH))
    `XKFB_ASSERT_IMP(a_col_bound, aclk, aresetn, state_reg == ST_UPD,
        (col_reg < trial_reg) && (pos_reg < n_reg))
    `XKFB_ASSERT_IMP(a_div_when, aclk, aresetn, div_stat.done, state_reg == ST_DIV)
    `XKFB_ASSERT_NXT(a_start_div, aclk, aresetn, div_start, div_stat.busy)

endmodule
